@@ rtl/anbsplit_pkg.sv @@
// ============================================================================
// anbsplit_pkg
// Shared types and constants of the start-code unit splitter: parser
// states, opcodes, byte codes and the command beat passed front to back.
// ============================================================================
package anbsplit_pkg;

    // input opcodes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // byte codes of the start code
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    // held zero limit inside a unit
    localparam logic [1:0] HELD_MAX = 2'd3;

    // width of a zero run in one command (up to four zeros)
    localparam int unsigned ZCNT_W = 3;

    // parser state
    typedef enum logic [1:0] {
        ST_SEARCH0,
        ST_SEARCH1,
        ST_SEARCH2,
        ST_IN_UNIT
    } anbsplit_state_t;

    // one command beat: a run of zeros, an optional byte, an optional marker
    typedef struct packed {
        logic [ZCNT_W-1:0] zero_count;
        logic              has_byte;
        logic [7:0]        data;
        logic              marker;
        logic              aborted;
    } anbsplit_cmd_t;

endpackage

@@ rtl/annexb_nal_unit_splitter_unit.sv @@
// ============================================================================
// annexb_nal_unit_splitter_unit
// Annex B start-code splitter: stream bytes in, unit payload bytes and
// end-of-unit markers out, both sides as queues.
// ============================================================================
// One stream beat is taken every cycle while full is low; the parser decides
// all results of a beat in that same cycle and posts them as one command into
// a queue of QUEUE_DEPTH entries. The expander then gives one result beat per
// cycle while the consumer pops, so an item with n results (up to five) takes
// n output beats; a beat with no result takes no queue entry. Full rises only
// when the command queue is full, which happens when the consumer pops slower
// than results are made. Results pass the queue, then the output register.
module annexb_nal_unit_splitter_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       opcode,
    input  logic [7:0] stream_byte,
    input  logic       end_of_stream,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] payload_byte,
    output logic       has_byte,
    output logic       end_of_unit,
    output logic       aborted,
    output logic       last
);

    logic                        accept;
    logic                        cmd_valid;
    anbsplit_pkg::anbsplit_cmd_t cmd;
    anbsplit_pkg::anbsplit_cmd_t head;
    logic                        head_valid;
    logic                        head_take;

    // input beat handshake
    assign accept = push && !full;

    // parser front end
    anbsplit_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .opcode        (opcode),
        .stream_byte   (stream_byte),
        .end_of_stream (end_of_stream),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd)
    );

    // command queue
    anbsplit_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_valid),
        .wr_data   (cmd),
        .rd_en     (head_take),
        .rd_data   (head),
        .not_empty (head_valid),
        .full      (full)
    );

    // result expander
    anbsplit_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .head_take    (head_take),
        .pop          (pop),
        .empty        (empty),
        .payload_byte (payload_byte),
        .has_byte     (has_byte),
        .end_of_unit  (end_of_unit),
        .aborted      (aborted),
        .last         (last)
    );

endmodule

@@ rtl/anbsplit_front.sv @@
// ============================================================================
// anbsplit_front
// Parser front end: takes one stream beat per cycle while accept is high,
// tracks start code search and held zeros; one command per beat with results.
// ============================================================================
module anbsplit_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic                    opcode,
    input  logic [7:0]              stream_byte,
    input  logic                    end_of_stream,
    output logic                    cmd_valid,
    output anbsplit_pkg::anbsplit_cmd_t cmd
);

    anbsplit_pkg::anbsplit_state_t state_reg;
    anbsplit_pkg::anbsplit_state_t state_next;
    logic [1:0] held_zeros_reg;
    logic [1:0] held_zeros_next;

    logic       opened;
    logic       pre_zero;
    logic [1:0] flush_zeros;
    logic [1:0] eos_zeros;
    logic       has_byte;
    logic       marker;
    logic       aborted;

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= anbsplit_pkg::ST_SEARCH0;
            held_zeros_reg <= 2'd0;
        end
        else if (accept)
        begin
            state_reg      <= state_next;
            held_zeros_reg <= held_zeros_next;
        end
    end

    // classify the beat and build its command
    always_comb
    begin
        state_next      = state_reg;
        held_zeros_next = held_zeros_reg;
        opened          = 1'b0;
        pre_zero        = 1'b0;
        flush_zeros     = 2'd0;
        eos_zeros       = 2'd0;
        has_byte        = 1'b0;
        marker          = 1'b0;
        aborted         = 1'b0;

        if (opcode == anbsplit_pkg::OP_RESTART)
        begin
            marker          = (state_reg == anbsplit_pkg::ST_IN_UNIT);
            aborted         = marker;
            state_next      = anbsplit_pkg::ST_SEARCH0;
            held_zeros_next = 2'd0;
        end
        else
        begin
            case (state_reg)
                anbsplit_pkg::ST_SEARCH1:
                begin
                    state_next = (stream_byte == anbsplit_pkg::BYTE_ZERO) ?
                                 anbsplit_pkg::ST_SEARCH2 : anbsplit_pkg::ST_SEARCH0;
                end
                anbsplit_pkg::ST_SEARCH2:
                begin
                    if (stream_byte == anbsplit_pkg::BYTE_ONE)
                    begin
                        state_next      = anbsplit_pkg::ST_IN_UNIT;
                        held_zeros_next = 2'd0;
                        opened          = 1'b1;
                    end
                    else if (stream_byte != anbsplit_pkg::BYTE_ZERO)
                    begin
                        state_next = anbsplit_pkg::ST_SEARCH0;
                    end
                end
                anbsplit_pkg::ST_IN_UNIT:
                begin
                    if (stream_byte == anbsplit_pkg::BYTE_ZERO)
                    begin
                        // fourth zero pushes out the oldest held one
                        if (held_zeros_reg == anbsplit_pkg::HELD_MAX)
                            pre_zero = 1'b1;
                        else
                            held_zeros_next = held_zeros_reg + 2'd1;
                    end
                    else if (stream_byte == anbsplit_pkg::BYTE_ONE &&
                             (held_zeros_reg inside {[2'd2:2'd3]}))
                    begin
                        // start code closes the unit and opens a new one
                        marker          = 1'b1;
                        held_zeros_next = 2'd0;
                        opened          = 1'b1;
                    end
                    else
                    begin
                        flush_zeros     = held_zeros_reg;
                        has_byte        = 1'b1;
                        held_zeros_next = 2'd0;
                    end
                end
                default:
                begin
                    state_next = (stream_byte == anbsplit_pkg::BYTE_ZERO) ?
                                 anbsplit_pkg::ST_SEARCH1 : anbsplit_pkg::ST_SEARCH0;
                end
            endcase

            // end of stream closes a unit that was open before this beat
            if (end_of_stream)
            begin
                if (state_next == anbsplit_pkg::ST_IN_UNIT && !opened)
                begin
                    eos_zeros = held_zeros_next;
                    marker    = 1'b1;
                end
                state_next      = anbsplit_pkg::ST_SEARCH0;
                held_zeros_next = 2'd0;
            end
        end

        cmd.zero_count = {2'b00, pre_zero} + {1'b0, flush_zeros} + {1'b0, eos_zeros};
        cmd.has_byte   = has_byte;
        cmd.data       = stream_byte;
        cmd.marker     = marker;
        cmd.aborted    = aborted;
        cmd_valid      = accept && ((cmd.zero_count != '0) || has_byte || marker);
    end

`ifndef SYNTHESIS
    // zeros are only ever held inside a unit
    assert property (@(posedge clk) disable iff (!rst_n)
        (held_zeros_reg != 2'd0) |-> (state_reg == anbsplit_pkg::ST_IN_UNIT))
        else $error("held zeros outside a unit");

    // a restart never produces bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && opcode == anbsplit_pkg::OP_RESTART) |->
        (cmd.zero_count == '0 && !cmd.has_byte && cmd.marker && cmd.aborted))
        else $error("restart command carries data");
`endif

endmodule

@@ rtl/anbsplit_queue.sv @@
// ============================================================================
// anbsplit_queue
// Small command queue between the parser and the result expander, so that
// each side can stall on its own.
// ============================================================================
module anbsplit_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  anbsplit_pkg::anbsplit_cmd_t wr_data,
    input  logic                        rd_en,
    output anbsplit_pkg::anbsplit_cmd_t rd_data,
    output logic                        not_empty,
    output logic                        full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    anbsplit_pkg::anbsplit_cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    assign rd_data   = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_FULL);

`ifndef SYNTHESIS
    // no write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en)
        else $error("queue overflow");

    // no read from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> not_empty)
        else $error("queue underflow");
`endif

endmodule

@@ rtl/anbsplit_back.sv @@
// ============================================================================
// anbsplit_back
// Result expander: turns each command into its zero, byte and marker
// beats, one per cycle while pop allows, through a single output register.
// ============================================================================
module anbsplit_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  anbsplit_pkg::anbsplit_cmd_t head,
    input  logic                        head_valid,
    output logic                        head_take,
    input  logic                        pop,
    output logic                        empty,
    output logic [7:0]                  payload_byte,
    output logic                        has_byte,
    output logic                        end_of_unit,
    output logic                        aborted,
    output logic                        last
);

    logic                        busy_reg;
    logic                        busy_next;
    anbsplit_pkg::anbsplit_cmd_t work_reg;
    anbsplit_pkg::anbsplit_cmd_t work_next;
    anbsplit_pkg::anbsplit_cmd_t cur;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_has_reg;
    logic       out_eou_reg;
    logic       out_ab_reg;
    logic       out_last_reg;

    logic       advance;
    logic       step;
    logic [7:0] step_byte;
    logic       step_has;
    logic       step_eou;
    logic       step_ab;
    logic       step_last;

    // pick the command being expanded and work out its next beat
    always_comb
    begin
        advance   = !out_valid_reg || pop;
        cur       = busy_reg ? work_reg : head;
        head_take = advance && !busy_reg && head_valid;
        step      = advance && (busy_reg || head_valid);
        work_next = cur;
        step_byte = 8'h00;
        step_has  = 1'b0;
        step_eou  = 1'b0;
        step_ab   = 1'b0;
        step_last = 1'b0;

        if (cur.zero_count != '0)
        begin
            step_has             = 1'b1;
            work_next.zero_count = cur.zero_count - 1'b1;
            step_last = (cur.zero_count == anbsplit_pkg::ZCNT_W'(1)) &&
                        !cur.has_byte && !cur.marker;
        end
        else if (cur.has_byte)
        begin
            step_byte          = cur.data;
            step_has           = 1'b1;
            work_next.has_byte = 1'b0;
            step_last          = !cur.marker;
        end
        else
        begin
            step_eou         = 1'b1;
            step_ab          = cur.aborted;
            work_next.marker = 1'b0;
            step_last        = 1'b1;
        end

        busy_next = busy_reg;
        if (step)
            busy_next = !step_last;
    end

    // expander control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (advance)
                out_valid_reg <= step;
        end
    end

    // working copy and output payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            work_reg     <= work_next;
            out_byte_reg <= step_byte;
            out_has_reg  <= step_has;
            out_eou_reg  <= step_eou;
            out_ab_reg   <= step_ab;
            out_last_reg <= step_last;
        end
    end

    assign empty        = !out_valid_reg;
    assign payload_byte = out_byte_reg;
    assign has_byte     = out_has_reg;
    assign end_of_unit  = out_eou_reg;
    assign aborted      = out_ab_reg;
    assign last         = out_last_reg;

`ifndef SYNTHESIS
    // a busy expander always has beats left to give
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (work_reg.zero_count != '0 || work_reg.has_byte || work_reg.marker))
        else $error("expander busy with nothing left");

    // a new command is only taken once the previous one is done
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && !step_last) |=> busy_reg)
        else $error("expander dropped part of a command");
`endif

endmodule

@@ tb/annexb_nal_unit_splitter_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// annexb_nal_unit_splitter_unit_tb
// Self-checking bench for the start-code unit splitter. A short directed
// table opens the run, then random elementary streams built from start
// codes and payload runs rich in 00 and 01 bytes. Every accepted stream
// beat goes through a local model of the parser; unit result beats are
// checked field by field in order. Four flow-control phases vary idling on
// the push side and stalling on the pop side.
// ============================================================================
module annexb_nal_unit_splitter_unit_tb;

    // one unit result beat
    typedef struct packed {
        logic [7:0] pbyte;
        logic       hasb;
        logic       eou;
        logic       ab;
        logic       lst;
    } unit_res_t;

    // how a stream beat is checked
    localparam logic [1:0] CHK_MODEL = 2'b00;  // local model decides
    localparam logic [1:0] CHK_QUIET = 2'b10;  // no result at all
    localparam logic [1:0] CHK_ONE   = 2'b11;  // exactly the fixed result

    // one stream beat, with an optional fixed expectation
    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       eos;
        logic [1:0] chk;
        unit_res_t  fixed;
    } stream_beat_t;

    localparam unit_res_t NO_RES     = '0;
    localparam unit_res_t EOU_MARK   = {8'h00, 1'b0, 1'b1, 1'b0, 1'b1};
    localparam unit_res_t ABORT_MARK = {8'h00, 1'b0, 1'b1, 1'b1, 1'b1};
    localparam int        N_DIRECTED = 28;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       push          = 1'b0;
    logic       full;
    logic       opcode        = anbsplit_pkg::OP_BYTE;
    logic [7:0] stream_byte   = 8'h00;
    logic       end_of_stream = 1'b0;
    logic       empty;
    logic       pop           = 1'b0;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic       end_of_unit;
    logic       aborted;
    logic       last;

    stream_beat_t                  stream_q[$];
    unit_res_t                     unit_out_q[$];
    unit_res_t                     step_out_q[$];
    anbsplit_pkg::anbsplit_state_t sp_state = anbsplit_pkg::ST_SEARCH0;
    logic [1:0]                    sp_held  = 2'd0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int beats_in       = 0;
    int results_out    = 0;
    int units_closed   = 0;
    int units_aborted  = 0;
    int i;

    annexb_nal_unit_splitter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .stream_byte   (stream_byte),
        .end_of_stream (end_of_stream),
        .empty         (empty),
        .pop           (pop),
        .payload_byte  (payload_byte),
        .has_byte      (has_byte),
        .end_of_unit   (end_of_unit),
        .aborted       (aborted),
        .last          (last)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // local parser model
    // ------------------------------------------------------------------
    task automatic emit(input logic [7:0] b, input logic hb, input logic eu, input logic ab);
        unit_res_t r;
        r = {b, hb, eu, ab, 1'b0};
        step_out_q.push_back(r);
    endtask

    // pass on every held zero
    task automatic release_held();
        while (sp_held != 2'd0)
        begin
            emit(anbsplit_pkg::BYTE_ZERO, 1'b1, 1'b0, 1'b0);
            sp_held = sp_held - 2'd1;
        end
    endtask

    task automatic split_step(input stream_beat_t s);
        logic      opened;
        unit_res_t tail;
        opened = 1'b0;
        step_out_q.delete();
        if (s.op == anbsplit_pkg::OP_RESTART)
        begin
            // restart drops an open unit with an abort marker
            if (sp_state == anbsplit_pkg::ST_IN_UNIT)
                emit(8'h00, 1'b0, 1'b1, 1'b1);
            sp_state = anbsplit_pkg::ST_SEARCH0;
            sp_held  = 2'd0;
        end
        else
        begin
            case (sp_state)
                anbsplit_pkg::ST_SEARCH1:
                    sp_state = (s.data == anbsplit_pkg::BYTE_ZERO) ?
                               anbsplit_pkg::ST_SEARCH2 : anbsplit_pkg::ST_SEARCH0;
                anbsplit_pkg::ST_SEARCH2:
                begin
                    if (s.data == anbsplit_pkg::BYTE_ONE)
                    begin
                        sp_state = anbsplit_pkg::ST_IN_UNIT;
                        sp_held  = 2'd0;
                        opened   = 1'b1;
                    end
                    else if (s.data != anbsplit_pkg::BYTE_ZERO)
                        sp_state = anbsplit_pkg::ST_SEARCH0;
                end
                anbsplit_pkg::ST_IN_UNIT:
                begin
                    if (s.data == anbsplit_pkg::BYTE_ZERO)
                    begin
                        // a fourth zero pushes out the oldest held one
                        if (sp_held >= anbsplit_pkg::HELD_MAX)
                            emit(anbsplit_pkg::BYTE_ZERO, 1'b1, 1'b0, 1'b0);
                        else
                            sp_held = sp_held + 2'd1;
                    end
                    else if (s.data == anbsplit_pkg::BYTE_ONE && sp_held >= 2'd2)
                    begin
                        // start code inside a unit: close it, drop held zeros
                        emit(8'h00, 1'b0, 1'b1, 1'b0);
                        sp_held = 2'd0;
                        opened  = 1'b1;
                    end
                    else
                    begin
                        release_held();
                        emit(s.data, 1'b1, 1'b0, 1'b0);
                    end
                end
                default:
                    sp_state = (s.data == anbsplit_pkg::BYTE_ZERO) ?
                               anbsplit_pkg::ST_SEARCH1 : anbsplit_pkg::ST_SEARCH0;
            endcase
            // end of stream closes a unit unless this beat just opened it
            if (s.eos)
            begin
                if (sp_state == anbsplit_pkg::ST_IN_UNIT && !opened)
                begin
                    release_held();
                    emit(8'h00, 1'b0, 1'b1, 1'b0);
                end
                sp_state = anbsplit_pkg::ST_SEARCH0;
                sp_held  = 2'd0;
            end
        end
        if (step_out_q.size() > 0)
        begin
            tail     = step_out_q.pop_back();
            tail.lst = 1'b1;
            step_out_q.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    function automatic stream_beat_t directed_row(input int idx);
        stream_beat_t r;
        case (idx)
            // bytes and restart before any start code
            0:  r = {anbsplit_pkg::OP_BYTE,    8'hFF, 1'b0, CHK_QUIET, NO_RES};
            1:  r = {anbsplit_pkg::OP_RESTART, 8'hA5, 1'b1, CHK_QUIET, NO_RES};
            // start code, then a plain byte
            2:  r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            3:  r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            4:  r = {anbsplit_pkg::OP_BYTE,    8'h01, 1'b0, CHK_QUIET, NO_RES};
            5:  r = {anbsplit_pkg::OP_BYTE,    8'hFF, 1'b0, CHK_ONE,
                     {8'hFF, 1'b1, 1'b0, 1'b0, 1'b1}};
            // three held zeros, then a fourth one
            6:  r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            7:  r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            8:  r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            9:  r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_ONE,
                     {8'h00, 1'b1, 1'b0, 1'b0, 1'b1}};
            // start code over three held zeros
            10: r = {anbsplit_pkg::OP_BYTE,    8'h01, 1'b0, CHK_ONE, EOU_MARK};
            // held zero released by a data byte
            11: r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            12: r = {anbsplit_pkg::OP_BYTE,    8'h80, 1'b0, CHK_MODEL, NO_RES};
            // start code over two held zeros
            13: r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            14: r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            15: r = {anbsplit_pkg::OP_BYTE,    8'h01, 1'b0, CHK_ONE, EOU_MARK};
            // unit with no bytes still gets its marker
            16: r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            17: r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            18: r = {anbsplit_pkg::OP_BYTE,    8'h01, 1'b0, CHK_ONE, EOU_MARK};
            // 01 with no held zero is payload
            19: r = {anbsplit_pkg::OP_BYTE,    8'h01, 1'b0, CHK_ONE,
                     {8'h01, 1'b1, 1'b0, 1'b0, 1'b1}};
            // end of stream releases held zeros and closes the unit
            20: r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b1, CHK_MODEL, NO_RES};
            // end of stream on the start code byte
            21: r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            22: r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            23: r = {anbsplit_pkg::OP_BYTE,    8'h01, 1'b1, CHK_QUIET, NO_RES};
            // restart of an empty open unit
            24: r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            25: r = {anbsplit_pkg::OP_BYTE,    8'h00, 1'b0, CHK_QUIET, NO_RES};
            26: r = {anbsplit_pkg::OP_BYTE,    8'h01, 1'b0, CHK_QUIET, NO_RES};
            27: r = {anbsplit_pkg::OP_RESTART, 8'h00, 1'b1, CHK_ONE, ABORT_MARK};
            default: r = '0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random stream builder
    // ------------------------------------------------------------------
    task automatic queue_beat(input logic op, input logic [7:0] b, input logic eos);
        stream_beat_t s;
        s = {op, b, eos, CHK_MODEL, NO_RES};
        stream_q.push_back(s);
    endtask

    function automatic logic [7:0] payload_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return anbsplit_pkg::BYTE_ZERO;
        else if (r < 45)
            return anbsplit_pkg::BYTE_ONE;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic queue_streams(input int target);
        int made;
        int kind;
        int zr;
        int len;
        int k;
        made = 0;
        while (made < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 12)
            begin
                // noise: random bytes, restarts and stream ends
                queue_beat(($urandom_range(0, 9) == 0) ?
                           anbsplit_pkg::OP_RESTART : anbsplit_pkg::OP_BYTE,
                           8'($urandom_range(0, 255)), ($urandom_range(0, 19) == 0));
                made++;
            end
            else
            begin
                // start code of two or three zeros
                zr = $urandom_range(2, 3);
                for (k = 0; k < zr; k++)
                    queue_beat(anbsplit_pkg::OP_BYTE, anbsplit_pkg::BYTE_ZERO, 1'b0);
                queue_beat(anbsplit_pkg::OP_BYTE, anbsplit_pkg::BYTE_ONE,
                           ($urandom_range(0, 19) == 0));
                made += zr + 1;
                // payload
                len = $urandom_range(0, 10);
                for (k = 0; k < len; k++)
                    queue_beat(anbsplit_pkg::OP_BYTE, payload_pick(), 1'b0);
                made += len;
                // unit end: restart, stream end, or the next start code
                kind = $urandom_range(0, 99);
                if (kind < 15)
                begin
                    queue_beat(anbsplit_pkg::OP_RESTART, 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
                    made++;
                end
                else if (kind < 30)
                begin
                    queue_beat(anbsplit_pkg::OP_BYTE, payload_pick(), 1'b1);
                    made++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("mismatch at result beat %0d: %s", results_out, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // push side: predict accepted beats, present the next one
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : sender
        stream_beat_t cur;
        logic         go;
        if (push && !full)
        begin
            cur = stream_q.pop_front();
            split_step(cur);
            if (cur.chk == CHK_MODEL)
            begin
                foreach (step_out_q[k])
                    unit_out_q.push_back(step_out_q[k]);
            end
            else if (cur.chk == CHK_ONE)
                unit_out_q.push_back(cur.fixed);
            beats_in++;
        end
        // hold a beat that was not taken, else maybe idle
        go = push && full;
        if (!go && stream_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            go = 1'b1;
        if (go)
        begin
            cur           = stream_q[0];
            push          <= 1'b1;
            opcode        <= cur.op;
            stream_byte   <= cur.data;
            end_of_stream <= cur.eos;
        end
        else
            push <= 1'b0;
    end

    // ------------------------------------------------------------------
    // pop side: check result beats against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : receiver
        unit_res_t want;
        if (pop && !empty)
        begin
            if (unit_out_q.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                want = unit_out_q.pop_front();
                check_field("payload_byte", payload_byte, want.pbyte);
                check_field("has_byte", 8'(has_byte), 8'(want.hasb));
                check_field("end_of_unit", 8'(end_of_unit), 8'(want.eou));
                check_field("aborted", 8'(aborted), 8'(want.ab));
                check_field("last", 8'(last), 8'(want.lst));
            end
            if (end_of_unit)
                units_closed++;
            if (end_of_unit && aborted)
                units_aborted++;
            results_out++;
        end
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // phase: no idling, directed table first
        for (i = 0; i < N_DIRECTED; i++)
            stream_q.push_back(directed_row(i));
        queue_streams(75);
        while (stream_q.size() != 0) @(posedge clk);

        // phase: push side idle most cycles
        @(negedge clk);
        send_idle_pct  = 80;
        recv_stall_pct = 0;
        queue_streams(100);
        while (stream_q.size() != 0) @(posedge clk);

        // phase: pop side stalls most cycles
        @(negedge clk);
        send_idle_pct  = 0;
        recv_stall_pct = 80;
        queue_streams(100);
        while (stream_q.size() != 0) @(posedge clk);

        // phase: both sides idle now and then
        @(negedge clk);
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        queue_streams(100);
        while (stream_q.size() != 0) @(posedge clk);

        // drain, then watch for stray results
        @(negedge clk);
        recv_stall_pct = 0;
        while (unit_out_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d stream beats and %0d result beats in four flow phases",
                 beats_in, results_out);
        $display("units closed %0d, of them aborted by restart %0d, mismatches %0d",
                 units_closed, units_aborted, mismatches);
        if (mismatches == 0)
            $display("annexb_nal_unit_splitter_unit_tb passed");
        else
            $display("annexb_nal_unit_splitter_unit_tb failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("annexb_nal_unit_splitter_unit_tb failed");
        $finish;
    end

endmodule

@@ annexb_nal_unit_splitter_unit.f @@
rtl/anbsplit_pkg.sv
rtl/anbsplit_front.sv
rtl/anbsplit_queue.sv
rtl/anbsplit_back.sv
rtl/annexb_nal_unit_splitter_unit.sv
tb/annexb_nal_unit_splitter_unit_tb.sv
